// File: hdl/prsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_pkg
// Shared types, constants and pointer helpers of the packet ring.
// ----------------------------------------------------------------------------
package prsr_pkg;

    localparam int RING_DEPTH = 32;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int OP_W       = 2;
    localparam int LEN_W      = 32;
    localparam int TAG_W      = 16;
    localparam int ENTRY_W    = LEN_W + TAG_W;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 37;
    localparam int COUNT_W    = 6;

    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_FIELDS_W = LEN_W + TAG_W + FILL_W + 2 * COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;
    localparam int M_TUSER_W  = STATUS_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD         = 2'd0,
        OP_GET         = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_RELEASE_TAG = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_RING_FULL     = 3'd1,
        ST_NONE_AVAIL    = 3'd2,
        ST_NONE_RELEASE  = 3'd3,
        ST_TAG_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [LEN_W-1:0]     out_length;
        logic [TAG_W-1:0]     out_tag;
        logic [FILL_W-1:0]    fill_level;
        logic [COUNT_W-1:0]   available_count;
        logic [COUNT_W-1:0]   handed_out_count;
    } result_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// File: hdl/prsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/prsr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_engine
// Ring sequencer: decodes one op, reads and rewrites the entry memory,
// scans handed-out entries by tag and compacts the ring behind a hit.
// ----------------------------------------------------------------------------
module prsr_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  prsr_pkg::op_t                 in_op,
    input  logic [prsr_pkg::LEN_W-1:0]    in_len,
    input  logic [prsr_pkg::TAG_W-1:0]    in_tag,
    output logic                          res_valid,
    input  logic                          res_take,
    output prsr_pkg::result_t             res
);
    import prsr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_READ     = 6'b000100,
        S_SCAN     = 6'b001000,
        S_SHIFT    = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    oldest_reg, oldest_next;
    logic [PTR_W-1:0]    avail_ptr_reg, avail_ptr_next;
    logic [PTR_W-1:0]    free_ptr_reg, free_ptr_next;
    logic [CNT_W-1:0]    avail_cnt_reg, avail_cnt_next;
    logic [CNT_W-1:0]    handed_cnt_reg, handed_cnt_next;
    logic [FILL_W-1:0]   bytes_reg, bytes_next;

    op_t                 op_reg, op_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    status_t             status_reg, status_next;
    logic [LEN_W-1:0]    olen_reg, olen_next;
    logic [TAG_W-1:0]    otag_reg, otag_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;

    logic                mem_we;
    logic [PTR_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [PTR_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;
    logic [LEN_W-1:0]    rd_len;
    logic [TAG_W-1:0]    rd_tag;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    behind;

    prsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_len    = mem_rdata[LEN_W-1:0];
    assign rd_tag    = mem_rdata[ENTRY_W-1:LEN_W];
    assign total     = avail_cnt_reg + handed_cnt_reg;
    assign behind    = total - idx_reg - 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status           = status_reg;
    assign res.out_length       = olen_reg;
    assign res.out_tag          = otag_reg;
    assign res.fill_level       = bytes_reg;
    assign res.available_count  = COUNT_W'(avail_cnt_reg);
    assign res.handed_out_count = COUNT_W'(handed_cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        avail_ptr_next  = avail_ptr_reg;
        free_ptr_next   = free_ptr_reg;
        avail_cnt_next  = avail_cnt_reg;
        handed_cnt_next = handed_cnt_reg;
        bytes_next      = bytes_reg;
        op_next         = op_reg;
        len_next        = len_reg;
        tag_next        = tag_reg;
        status_next     = status_reg;
        olen_next       = olen_reg;
        otag_next       = otag_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = ptr_inc(cur_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    len_next   = in_len;
                    tag_next   = in_tag;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next = ST_OK;
                olen_next   = '0;
                otag_next   = '0;
                state_next  = S_DONE;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (total == CNT_W'(RING_DEPTH))
                        begin
                            status_next = ST_RING_FULL;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = free_ptr_reg;
                            mem_wdata      = {tag_reg, len_reg};
                            free_ptr_next  = ptr_inc(free_ptr_reg);
                            avail_cnt_next = avail_cnt_reg + 1'b1;
                            bytes_next     = bytes_reg + FILL_W'(len_reg);
                        end
                    end
                    OP_GET:
                    begin
                        mem_raddr = avail_ptr_reg;
                        if (avail_cnt_reg == '0)
                        begin
                            status_next = ST_NONE_AVAIL;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    OP_RELEASE:
                    begin
                        mem_raddr = oldest_reg;
                        if (handed_cnt_reg == '0)
                        begin
                            status_next = ST_NONE_RELEASE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    OP_RELEASE_TAG:
                    begin
                        mem_raddr = oldest_reg;
                        cur_next  = oldest_reg;
                        idx_next  = '0;
                        if (handed_cnt_reg == '0)
                        begin
                            status_next = ST_NONE_RELEASE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end

            S_READ:
            begin
                olen_next  = rd_len;
                otag_next  = rd_tag;
                state_next = S_DONE;
                if (op_reg == OP_GET)
                begin
                    avail_ptr_next  = ptr_inc(avail_ptr_reg);
                    avail_cnt_next  = avail_cnt_reg - 1'b1;
                    handed_cnt_next = handed_cnt_reg + 1'b1;
                end
                else
                begin
                    bytes_next      = bytes_reg - FILL_W'(rd_len);
                    oldest_next     = ptr_inc(oldest_reg);
                    handed_cnt_next = handed_cnt_reg - 1'b1;
                end
            end

            S_SCAN:
            begin
                if (rd_tag == tag_reg)
                begin
                    olen_next       = rd_len;
                    otag_next       = rd_tag;
                    bytes_next      = bytes_reg - FILL_W'(rd_len);
                    handed_cnt_next = handed_cnt_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        oldest_next = ptr_inc(oldest_reg);
                        state_next  = S_DONE;
                    end
                    else if (behind == '0)
                    begin
                        avail_ptr_next = ptr_dec(avail_ptr_reg);
                        free_ptr_next  = ptr_dec(free_ptr_reg);
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        rem_next   = behind;
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == handed_cnt_reg - 1'b1)
                begin
                    status_next = ST_TAG_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cur_next = ptr_inc(cur_reg);
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_raddr = ptr_inc(ptr_inc(cur_reg));
                cur_next  = ptr_inc(cur_reg);
                rem_next  = rem_reg - 1'b1;
                if (rem_reg == CNT_W'(1))
                begin
                    avail_ptr_next = ptr_dec(avail_ptr_reg);
                    free_ptr_next  = ptr_dec(free_ptr_reg);
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            oldest_reg     <= '0;
            avail_ptr_reg  <= '0;
            free_ptr_reg   <= '0;
            avail_cnt_reg  <= '0;
            handed_cnt_reg <= '0;
            bytes_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            avail_ptr_reg  <= avail_ptr_next;
            free_ptr_reg   <= free_ptr_next;
            avail_cnt_reg  <= avail_cnt_next;
            handed_cnt_reg <= handed_cnt_next;
            bytes_reg      <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        len_reg    <= len_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        olen_reg   <= olen_next;
        otag_reg   <= otag_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
    end

endmodule

// File: hdl/packet_ring_with_specific_release.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_ring_with_specific_release
// Receive ring of packet lengths and tags with in-order and tagged release.
//
// Input channel s_*: one item is one op (add, get, release oldest, release
// by tag) with a packet length and tag. Output channel m_*: one item per
// input item with status, length, tag, fill level and both counts.
// Add and failed ops go from dispatch straight to the result state, get and
// release oldest pass a read state first. Release by tag scans the
// handed-out entries one per cycle through the entry memory read port, then
// compacts the occupied entries behind the hit one per cycle with a read and
// a write each. One op is in work at a time; the next input item is taken
// once the result has moved into the output register.
// Reset clears pointers, counts and fill level; the entry memory is not
// cleared and needs no clearing pass. A stalled receiver holds the result
// in the output register; a second result then waits inside the sequencer
// and no further input item is accepted until the output frees.
// ----------------------------------------------------------------------------
module packet_ring_with_specific_release (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pkt_length [31:0], pkt_tag [47:32]
    input  logic [prsr_pkg::S_TDATA_W-1:0]    s_tdata,
    // op [1:0]
    input  logic [prsr_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_length [31:0], out_tag [47:32], fill_level [84:48],
    // available_count [90:85], handed_out_count [96:91], zero pad above
    output logic [prsr_pkg::M_TDATA_W-1:0]    m_tdata,
    // status [2:0]
    output logic [prsr_pkg::M_TUSER_W-1:0]    m_tuser
);
    import prsr_pkg::*;

    logic     res_valid;
    logic     res_take;
    logic     out_free;
    result_t  res;
    result_t  out_reg;
    logic     m_tvalid_reg;

    prsr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_len    (s_tdata[LEN_W-1:0]),
        .in_tag    (s_tdata[ENTRY_W-1:LEN_W]),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign res_take = res_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.handed_out_count, out_reg.available_count,
                       out_reg.fill_level, out_reg.out_tag, out_reg.out_length};

endmodule

// File: tb/tb_packet_ring_with_specific_release.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_ring_with_specific_release
// Self-checking testbench for the packet receive ring.
//
// A directed table covers the edge cases first: ops on an empty ring, extreme
// lengths and tags, tagged release that skips available entries, and hits
// both at the oldest handed-out entry and behind it. A random phase follows.
// It switches between fill, drain, balanced and noise modes so that the ring
// runs full and empty many times. A local ring predictor computes each result
// when its op is accepted. Every output item is checked field by field in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_packet_ring_with_specific_release;

    import prsr_pkg::*;

    localparam int DIR_ROWS   = 24;
    localparam int RAND_ITEMS = 800;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic             typed;
        result_t          want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    logic [LEN_W-1:0]      ring_len [RING_DEPTH];
    logic [TAG_W-1:0]      ring_tag [RING_DEPTH];
    int                    oldest_handed;
    int                    next_avail;
    int                    next_free;
    int                    n_avail;
    int                    n_handed;
    logic [FILL_W-1:0]     held_bytes;

    result_t               pending_results [$];
    int                    bad_results = 0;
    int                    results_seen = 0;
    stim_row_t             dir_rows [DIR_ROWS];

    packet_ring_with_specific_release uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t ring_predict(input op_t op, input logic [LEN_W-1:0] len,
                                             input logic [TAG_W-1:0] tag);
        result_t r;
        int      k;
        int      hit;
        int      p;
        int      total;
        int      cur;
        int      nxt;
        bit      found;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (n_avail + n_handed < RING_DEPTH)
                begin
                    ring_len[next_free] = len;
                    ring_tag[next_free] = tag;
                    next_free           = (next_free + 1) % RING_DEPTH;
                    n_avail++;
                    held_bytes          = held_bytes + FILL_W'(len);
                end
                else
                    r.status = ST_RING_FULL;
            end
            OP_GET:
            begin
                if (n_avail != 0)
                begin
                    r.out_length = ring_len[next_avail];
                    r.out_tag    = ring_tag[next_avail];
                    next_avail   = (next_avail + 1) % RING_DEPTH;
                    n_avail--;
                    n_handed++;
                end
                else
                    r.status = ST_NONE_AVAIL;
            end
            OP_RELEASE:
            begin
                if (n_handed != 0)
                begin
                    r.out_length  = ring_len[oldest_handed];
                    r.out_tag     = ring_tag[oldest_handed];
                    held_bytes    = held_bytes - FILL_W'(r.out_length);
                    oldest_handed = (oldest_handed + 1) % RING_DEPTH;
                    n_handed--;
                end
                else
                    r.status = ST_NONE_RELEASE;
            end
            default:
            begin
                found = 1'b0;
                hit   = 0;
                if (n_handed == 0)
                    r.status = ST_NONE_RELEASE;
                else
                begin
                    for (k = 0; k < n_handed && !found; k++)
                    begin
                        if (ring_tag[(oldest_handed + k) % RING_DEPTH] == tag)
                        begin
                            hit   = k;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = ST_TAG_NOT_FOUND;
                    else
                    begin
                        p            = (oldest_handed + hit) % RING_DEPTH;
                        total        = n_avail + n_handed;
                        r.out_length = ring_len[p];
                        r.out_tag    = ring_tag[p];
                        held_bytes   = held_bytes - FILL_W'(r.out_length);
                        n_handed--;
                        if (hit != 0)
                        begin
                            // shift everything behind the hit one slot toward it
                            cur = p;
                            for (k = 0; k < total - hit - 1; k++)
                            begin
                                nxt           = (cur + 1) % RING_DEPTH;
                                ring_len[cur] = ring_len[nxt];
                                ring_tag[cur] = ring_tag[nxt];
                                cur           = nxt;
                            end
                            next_avail = (next_avail + RING_DEPTH - 1) % RING_DEPTH;
                            next_free  = (next_free + RING_DEPTH - 1) % RING_DEPTH;
                        end
                        else
                            oldest_handed = (oldest_handed + 1) % RING_DEPTH;
                    end
                end
            end
        endcase
        r.fill_level       = held_bytes;
        r.available_count  = COUNT_W'(n_avail);
        r.handed_out_count = COUNT_W'(n_handed);
        return r;
    endfunction

    // Call right after a falling edge; returns right after a falling edge.
    task automatic send_op(input op_t op, input logic [LEN_W-1:0] len,
                           input logic [TAG_W-1:0] tag, input logic typed,
                           input result_t want, input bit calm);
        int      gap;
        result_t r;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, len};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        r = ring_predict(op, len, tag);
        pending_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    initial
    begin
        int               i;
        int               mode;
        int               w;
        int               idx;
        bit               calm;
        op_t              op;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;

        dir_rows = '{
            '{OP_GET,         32'h0,        16'h0,    1'b1,
              '{ST_NONE_AVAIL,    32'h0, 16'h0, 37'h0,          6'd0, 6'd0}},
            '{OP_RELEASE,     32'h0,        16'h0,    1'b1,
              '{ST_NONE_RELEASE,  32'h0, 16'h0, 37'h0,          6'd0, 6'd0}},
            '{OP_RELEASE_TAG, 32'h0,        16'hFFFF, 1'b1,
              '{ST_NONE_RELEASE,  32'h0, 16'h0, 37'h0,          6'd0, 6'd0}},
            '{OP_ADD,         32'hFFFFFFFF, 16'hFFFF, 1'b1,
              '{ST_OK,            32'h0, 16'h0, 37'hFFFFFFFF,   6'd1, 6'd0}},
            '{OP_ADD,         32'h0,        16'h0,    1'b1,
              '{ST_OK,            32'h0, 16'h0, 37'hFFFFFFFF,   6'd2, 6'd0}},
            '{OP_ADD,         32'h1,        16'h1234, 1'b0, '0},
            '{OP_RELEASE,     32'h0,        16'h0,    1'b1,
              '{ST_NONE_RELEASE,  32'h0, 16'h0, 37'h100000000,  6'd3, 6'd0}},
            '{OP_RELEASE_TAG, 32'h0,        16'h1234, 1'b1,
              '{ST_NONE_RELEASE,  32'h0, 16'h0, 37'h100000000,  6'd3, 6'd0}},
            '{OP_GET,         32'h0,        16'h0,    1'b1,
              '{ST_OK, 32'hFFFFFFFF, 16'hFFFF, 37'h100000000,   6'd2, 6'd1}},
            '{OP_GET,         32'h0,        16'h0,    1'b0, '0},
            '{OP_GET,         32'h0,        16'h0,    1'b0, '0},
            '{OP_GET,         32'h0,        16'h0,    1'b1,
              '{ST_NONE_AVAIL,    32'h0, 16'h0, 37'h100000000,  6'd0, 6'd3}},
            '{OP_RELEASE_TAG, 32'h0,        16'h5555, 1'b1,
              '{ST_TAG_NOT_FOUND, 32'h0, 16'h0, 37'h100000000,  6'd0, 6'd3}},
            '{OP_RELEASE_TAG, 32'h0,        16'h0,    1'b0, '0},
            '{OP_ADD,         32'h7,        16'hABCD, 1'b0, '0},
            '{OP_ADD,         32'h8,        16'h1234, 1'b0, '0},
            '{OP_RELEASE_TAG, 32'h0,        16'hABCD, 1'b0, '0},
            '{OP_RELEASE,     32'h0,        16'h0,    1'b0, '0},
            '{OP_RELEASE_TAG, 32'h0,        16'h1234, 1'b0, '0},
            '{OP_GET,         32'h0,        16'h0,    1'b0, '0},
            '{OP_GET,         32'h0,        16'h0,    1'b0, '0},
            '{OP_RELEASE_TAG, 32'h0,        16'h1234, 1'b0, '0},
            '{OP_RELEASE,     32'h0,        16'h0,    1'b0, '0},
            '{OP_RELEASE,     32'h0,        16'h0,    1'b1,
              '{ST_NONE_RELEASE,  32'h0, 16'h0, 37'h0,          6'd0, 6'd0}}
        };

        oldest_handed = 0;
        next_avail    = 0;
        next_free     = 0;
        n_avail       = 0;
        n_handed      = 0;
        held_bytes    = '0;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            ring_len[i] = '0;
            ring_tag[i] = '0;
        end

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        calm = 1'b0;
        for (i = 0; i < DIR_ROWS; i++)
            send_op(dir_rows[i].op, dir_rows[i].len, dir_rows[i].tag,
                    dir_rows[i].typed, dir_rows[i].want, calm);

        mode = 0;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 60 == 0)
                mode = $urandom_range(0, 3);
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);

            // op mix: fill, drain, balanced, uniform noise
            w = $urandom_range(0, 99);
            case (mode)
                0:       op = (w < 65) ? OP_ADD : (w < 85) ? OP_GET :
                              (w < 90) ? OP_RELEASE : OP_RELEASE_TAG;
                1:       op = (w < 10) ? OP_ADD : (w < 45) ? OP_GET :
                              (w < 70) ? OP_RELEASE : OP_RELEASE_TAG;
                2:       op = (w < 30) ? OP_ADD : (w < 55) ? OP_GET :
                              (w < 75) ? OP_RELEASE : OP_RELEASE_TAG;
                default: op = op_t'($urandom_range(0, 3));
            endcase

            w = $urandom_range(0, 99);
            if (w < 10)
                len = '0;
            else if (w < 20)
                len = '1;
            else if (w < 50)
                len = LEN_W'($urandom_range(0, 255));
            else
                len = $urandom;

            w = $urandom_range(0, 99);
            if (op == OP_RELEASE_TAG && n_handed != 0 && w < 65)
            begin
                idx = (oldest_handed + $urandom_range(0, n_handed - 1)) % RING_DEPTH;
                tag = ring_tag[idx];
            end
            else if (op == OP_RELEASE_TAG && n_avail != 0 && w < 80)
            begin
                idx = (next_avail + $urandom_range(0, n_avail - 1)) % RING_DEPTH;
                tag = ring_tag[idx];
            end
            else if (w < 60 || mode == 3 && w < 70)
                tag = TAG_W'($urandom_range(0, 7));
            else if (w < 85)
                tag = TAG_W'($urandom);
            else
                tag = ($urandom_range(0, 1) == 0) ? '0 : '1;

            send_op(op, len, tag, 1'b0, '0, calm);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (bad_results == 0 && pending_results.size() == 0)
            $display("packet_ring_with_specific_release: match");
        else
            $display("packet_ring_with_specific_release: mismatch");
        $finish;
    end

    initial
    begin
        int stall;
        bit calm;
        int n;
        m_tready = 1'b0;
        calm     = 1'b0;
        n        = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            n++;
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status           = status_t'(m_tuser);
            got.out_length       = m_tdata[31:0];
            got.out_tag          = m_tdata[47:32];
            got.fill_level       = m_tdata[84:48];
            got.available_count  = m_tdata[90:85];
            got.handed_out_count = m_tdata[96:91];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d: unexpected item, status %0d len %h tag %h",
                             results_seen, got.status, got.out_length, got.out_tag);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.out_length !== want.out_length ||
                    got.out_tag !== want.out_tag || got.fill_level !== want.fill_level ||
                    got.available_count !== want.available_count ||
                    got.handed_out_count !== want.handed_out_count)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("result %0d: expected st %0d len %h tag %h fill %h av %0d ho %0d",
                                 results_seen, want.status, want.out_length, want.out_tag,
                                 want.fill_level, want.available_count,
                                 want.handed_out_count);
                        $display("result %0d: actual   st %0d len %h tag %h fill %h av %0d ho %0d",
                                 results_seen, got.status, got.out_length, got.out_tag,
                                 got.fill_level, got.available_count, got.handed_out_count);
                    end
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("packet_ring_with_specific_release: mismatch");
        $finish;
    end

endmodule
